@@ design/assert_macros.svh @@
// Assertion macros shared by the sorted list RTL.
// No dependencies; simulation-only bodies, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted (active low).
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/bstk_pkg.sv @@
// Package for the bounded sorted top-k list: sizes, request codes, types.
// No dependencies.
`default_nettype none
package bstk_pkg;
    localparam int ENTRIES = 16;
    localparam int CNT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W  = 6;
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;

    // request codes
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // one stored entry
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic              add;
        logic              clr;
        logic              rot;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
    } t_cell_ctrl;
endpackage
`default_nettype wire

@@ design/bstk_cell.sv @@
// One slot of the sorted list: holds an entry, decides locally on insert.
// Depends on bstk_pkg.
`default_nettype none
module bstk_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bstk_pkg::t_cell_ctrl i_ctrl,
    input  bstk_pkg::t_entry     i_prev,       // entry of the cell above
    input  wire                  i_prev_take,  // cell above takes the new entry or shifts
    input  bstk_pkg::t_entry     i_next,       // entry of the cell below (read rotation)
    output bstk_pkg::t_entry     o_entry,
    output logic                 o_take
);
    logic                        r_valid;
    logic [bstk_pkg::DATA_W-1:0] r_key;
    logic [bstk_pkg::DATA_W-1:0] r_x;
    logic [bstk_pkg::DATA_W-1:0] r_y;
    logic [bstk_pkg::DATA_W-1:0] r_z;

    // slot is empty or holds a strictly greater rank
    assign o_take = !r_valid || (r_key > i_ctrl.key);

    // valid bit: the only control state in the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.add) begin
            if (i_prev_take) begin
                r_valid <= i_prev.valid;
            end else if (o_take) begin
                r_valid <= 1'b1;
            end
        end else if (i_ctrl.rot) begin
            r_valid <= i_next.valid;
        end
    end

    // payload: shift down, load new, or rotate up
    always_ff @(posedge i_clk) begin
        if (i_ctrl.add) begin
            if (i_prev_take) begin
                r_key <= i_prev.key;
                r_x   <= i_prev.x;
                r_y   <= i_prev.y;
                r_z   <= i_prev.z;
            end else if (o_take) begin
                r_key <= i_ctrl.key;
                r_x   <= i_ctrl.x;
                r_y   <= i_ctrl.y;
                r_z   <= i_ctrl.z;
            end
        end else if (i_ctrl.rot) begin
            r_key <= i_next.key;
            r_x   <= i_next.x;
            r_y   <= i_next.y;
            r_z   <= i_next.z;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, x: r_x, y: r_y, z: r_z};
endmodule
`default_nettype wire

@@ design/bounded_sorted_top_k_list.sv @@
// Top level of the bounded sorted top-k list: request decode, cell row, read-out.
// Depends on bstk_pkg, bstk_cell and assert_macros.svh.
//
//  channel   | control          | payload
//  ----------+------------------+-------------------------------------------
//  request   | start / busy     | i_mode, i_rank, i_vec_x, i_vec_y, i_vec_z
//  result    | o_valid (strobe) | o_slot, o_occupied, o_slot_rank,
//            |                  | o_out_x, o_out_y, o_out_z, o_last
//
// Add and clear never raise busy, so a request may follow in the next cycle,
// since every cell decides on its own from its neighbor.
// A read rotates the cell row up by one per cycle until every slot has passed
// cell 0, which feeds the output register; results appear one per cycle, with
// the strobe registered from busy, and busy stays high until the last slot.
// Synchronous active-low reset empties every slot; no clearing pass.
// The receiver cannot stall: each result strobes for exactly one cycle.
`default_nettype none
`include "assert_macros.svh"
module bounded_sorted_top_k_list (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [bstk_pkg::MODE_W-1:0]          i_mode,
    input  wire [bstk_pkg::DATA_W-1:0]          i_rank,
    input  wire signed [bstk_pkg::DATA_W-1:0]   i_vec_x,
    input  wire signed [bstk_pkg::DATA_W-1:0]   i_vec_y,
    input  wire signed [bstk_pkg::DATA_W-1:0]   i_vec_z,
    output logic                                o_valid,
    output logic [bstk_pkg::SLOT_W-1:0]         o_slot,
    output logic                                o_occupied,
    output logic [bstk_pkg::DATA_W-1:0]         o_slot_rank,
    output logic signed [bstk_pkg::DATA_W-1:0]  o_out_x,
    output logic signed [bstk_pkg::DATA_W-1:0]  o_out_y,
    output logic signed [bstk_pkg::DATA_W-1:0]  o_out_z,
    output logic                                o_last
);
    localparam int N = bstk_pkg::ENTRIES;

    logic                         r_busy;
    logic                         n_busy;
    logic [bstk_pkg::CNT_W-1:0]   r_cnt;
    logic [bstk_pkg::CNT_W-1:0]   n_cnt;
    logic                         w_acc;
    logic                         w_cnt_last;
    bstk_pkg::t_cell_ctrl         w_ctrl;
    bstk_pkg::t_entry             w_entry [N];
    logic [N-1:0]                 w_take;
    logic [N-1:0]                 w_valid;

    logic                         r_val;
    logic [bstk_pkg::SLOT_W-1:0]  r_slot;
    logic                         r_occ;
    logic [bstk_pkg::DATA_W-1:0]  r_rank;
    logic [bstk_pkg::DATA_W-1:0]  r_x;
    logic [bstk_pkg::DATA_W-1:0]  r_y;
    logic [bstk_pkg::DATA_W-1:0]  r_z;
    logic                         r_last;

    assign busy       = r_busy;
    assign w_acc      = start && !r_busy;
    assign w_cnt_last = (r_cnt == bstk_pkg::CNT_W'(N - 1));

    // request decode into the cell control broadcast
    always_comb begin
        w_ctrl     = '0;
        w_ctrl.key = i_rank;
        w_ctrl.x   = i_vec_x;
        w_ctrl.y   = i_vec_y;
        w_ctrl.z   = i_vec_z;
        w_ctrl.rot = r_busy;
        if (w_acc) begin
            unique case (i_mode)
                bstk_pkg::MODE_ADD:   w_ctrl.add = 1'b1;
                bstk_pkg::MODE_CLEAR: w_ctrl.clr = 1'b1;
                default:              ;
            endcase
        end
    end

    // read sequencer: busy flag and slot counter
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (w_cnt_last) begin
                n_busy = 1'b0;
                n_cnt  = '0;
            end
        end else if (w_acc && i_mode == bstk_pkg::MODE_READ) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // row of cells; insert shifts down, read rotates up
    for (genvar g = 0; g < N; g++) begin : g_cell
        bstk_pkg::t_entry w_prev;
        logic             w_prev_take;
        if (g == 0) begin : g_first
            assign w_prev      = '0;
            assign w_prev_take = 1'b0;
        end else begin : g_rest
            assign w_prev      = w_entry[g-1];
            assign w_prev_take = w_take[g-1];
        end
        bstk_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_prev      (w_prev),
            .i_prev_take (w_prev_take),
            .i_next      (w_entry[(g + 1) % N]),
            .o_entry     (w_entry[g]),
            .o_take      (w_take[g])
        );
        assign w_valid[g] = w_entry[g].valid;
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 1'b0;
        end else begin
            r_val <= r_busy;
        end
    end

    // result payload from cell 0, zeroed when the slot is empty
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_slot <= bstk_pkg::SLOT_W'(r_cnt);
            r_occ  <= w_entry[0].valid;
            r_rank <= w_entry[0].valid ? w_entry[0].key : '0;
            r_x    <= w_entry[0].valid ? w_entry[0].x   : '0;
            r_y    <= w_entry[0].valid ? w_entry[0].y   : '0;
            r_z    <= w_entry[0].valid ? w_entry[0].z   : '0;
            r_last <= w_cnt_last;
        end
    end

    assign o_valid     = r_val;
    assign o_slot      = r_slot;
    assign o_occupied  = r_occ;
    assign o_slot_rank = r_rank;
    assign o_out_x     = r_x;
    assign o_out_y     = r_y;
    assign o_out_z     = r_z;
    assign o_last      = r_val && r_last;

    // checks
    `ASSERT_RST(a_strobe_from_busy, i_clk, i_rst_n, o_valid |-> $past(r_busy), "result without read")
    `ASSERT_RST(a_run_contiguous, i_clk, i_rst_n, (o_valid && !o_last) |=> o_valid, "read run broken")
    `ASSERT_RST(a_last_frees, i_clk, i_rst_n, o_last |-> !busy, "busy after final slot")
    `ASSERT_RST(a_valid_prefix, i_clk, i_rst_n, !r_busy |-> (((w_valid >> 1) & ~w_valid) == '0), "gap in occupied slots")
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_valid), "not idle after reset")
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for bounded_sorted_top_k_list: directed and random add, clear and read requests.
// Depends on bstk_pkg and bounded_sorted_top_k_list; a scoreboard class mirrors the list.
module testbench;
    import bstk_pkg::*;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned CALM_TAIL    = 60;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] Q16_NEG_ONE = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q16_ZERO    = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Q16_MIN     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q16_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RANK_MAX    = 32'hFFFF_FFFF;

    // one reported slot of a read-out
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              occupied;
        logic [DATA_W-1:0] rank;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic              last;
    } t_readout;

    // mirror of the sorted list plus the read-out slots still owed by the block
    class topk_scoreboard;
        t_entry      slots[ENTRIES];
        t_readout    pending_slots[$];
        int unsigned errors;

        function new();
            errors = 0;
            empty_list();
        endfunction

        function void empty_list();
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function int unsigned pending();
            return pending_slots.size();
        endfunction

        // apply one accepted request to the mirror
        function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] rank,
                                   logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                   logic [DATA_W-1:0] z);
            int       pos;
            t_readout r;
            case (mode)
                MODE_ADD: begin
                    // first empty slot or first strictly greater rank
                    pos = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (pos < 0 && (!slots[i].valid || slots[i].key > rank))
                            pos = i;
                    if (pos >= 0) begin
                        for (int i = ENTRIES - 1; i > pos; i--)
                            slots[i] = slots[i-1];
                        slots[pos] = '{valid: 1'b1, key: rank, x: x, y: y, z: z};
                    end
                end
                MODE_CLEAR: empty_list();
                MODE_READ: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        r.slot     = SLOT_W'(i);
                        r.occupied = slots[i].valid;
                        r.rank     = slots[i].valid ? slots[i].key : '0;
                        r.x        = slots[i].valid ? slots[i].x : '0;
                        r.y        = slots[i].valid ? slots[i].y : '0;
                        r.z        = slots[i].valid ? slots[i].z : '0;
                        r.last     = (i == ENTRIES - 1);
                        pending_slots.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                     logic [DATA_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, actual %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one strobed result with the oldest owed slot
        function void check_readout(t_readout got);
            t_readout exp_r;
            if (pending_slots.size() == 0) begin
                $error("result for slot %0d with no read pending", got.slot);
                errors++;
                return;
            end
            exp_r = pending_slots.pop_front();
            compare_field("slot", DATA_W'(exp_r.slot), DATA_W'(got.slot));
            compare_field("occupied", DATA_W'(exp_r.occupied), DATA_W'(got.occupied));
            compare_field("slot_rank", exp_r.rank, got.rank);
            compare_field("out_x", exp_r.x, got.x);
            compare_field("out_y", exp_r.y, got.y);
            compare_field("out_z", exp_r.z, got.z);
            compare_field("last", DATA_W'(exp_r.last), DATA_W'(got.last));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic [MODE_W-1:0]        i_mode  = MODE_ADD;
    logic [DATA_W-1:0]        i_rank  = '0;
    logic signed [DATA_W-1:0] i_vec_x = '0;
    logic signed [DATA_W-1:0] i_vec_y = '0;
    logic signed [DATA_W-1:0] i_vec_z = '0;
    logic                     busy;
    logic                     o_valid;
    logic [SLOT_W-1:0]        o_slot;
    logic                     o_occupied;
    logic [DATA_W-1:0]        o_slot_rank;
    logic signed [DATA_W-1:0] o_out_x;
    logic signed [DATA_W-1:0] o_out_y;
    logic signed [DATA_W-1:0] o_out_z;
    logic                     o_last;

    topk_scoreboard scoreboard;
    int unsigned    quiet_cycles = 0;

    bounded_sorted_top_k_list dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_rank      (i_rank),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_valid     (o_valid),
        .o_slot      (o_slot),
        .o_occupied  (o_occupied),
        .o_slot_rank (o_slot_rank),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_last      (o_last)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // monitor: results first, then the accepted request, then the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                scoreboard.check_readout('{slot: o_slot, occupied: o_occupied,
                                           rank: o_slot_rank, x: o_out_x, y: o_out_y,
                                           z: o_out_z, last: o_last});
            if (start && !busy)
                scoreboard.note_request(i_mode, i_rank, i_vec_x, i_vec_y, i_vec_z);
            if (o_valid || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // drive one request and hold it until the block takes it
    task automatic issue(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] rank,
                         input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                         input logic [DATA_W-1:0] z);
        start   <= 1'b1;
        i_mode  <= mode;
        i_rank  <= rank;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        do @(posedge i_clk); while (busy);
    endtask

    // drop start for a while, with junk on the payload
    task automatic idle_for(input int unsigned cycles);
        start   <= 1'b0;
        i_mode  <= MODE_W'($urandom);
        i_rank  <= $urandom;
        i_vec_x <= $urandom;
        i_vec_y <= $urandom;
        i_vec_z <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] random_component();
        case ($urandom_range(0, 11))
            0:       return Q16_MIN;
            1:       return Q16_MAX;
            2:       return Q16_NEG_ONE;
            3:       return Q16_ZERO;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_rank();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DATA_W'($urandom_range(0, 15));  // ties are common
            8:          return '0;
            9:          return RANK_MAX;
            default:    return $urandom;
        endcase
    endfunction

    // extremes, ties, full list, unused mode, clear
    task automatic run_directed();
        issue(MODE_READ, '0, '0, '0, '0);
        issue(MODE_ADD, '0, Q16_MAX, Q16_MAX, Q16_MAX);
        issue(MODE_ADD, RANK_MAX, Q16_MIN, Q16_MIN, Q16_MIN);
        issue(MODE_ADD, '0, Q16_NEG_ONE, Q16_ZERO, Q16_NEG_ONE);
        issue(MODE_READ, '0, '0, '0, '0);
        issue(MODE_UNUSED, 32'd5, Q16_NEG_ONE, Q16_NEG_ONE, Q16_NEG_ONE);
        // fill up the remaining slots
        for (int k = 0; k < ENTRIES - 3; k++)
            issue(MODE_ADD, DATA_W'((k * 37) % 50 + 1), $urandom, $urandom, $urandom);
        // full list, rank not smaller than any stored one: no change
        issue(MODE_ADD, RANK_MAX, Q16_NEG_ONE, Q16_NEG_ONE, Q16_NEG_ONE);
        // full list, small rank: last slot drops out
        issue(MODE_ADD, 32'd1, Q16_NEG_ONE, Q16_MAX, Q16_MIN);
        issue(MODE_READ, '0, '0, '0, '0);
        issue(MODE_CLEAR, RANK_MAX, Q16_MAX, Q16_MAX, Q16_MAX);
        issue(MODE_READ, '0, '0, '0, '0);
        issue(MODE_ADD, 32'd7, random_component(), random_component(), random_component());
        issue(MODE_READ, '0, '0, '0, '0);
    endtask

    // mostly adds with reads mixed in, rare clears, a little unused-mode noise
    task automatic run_random();
        int unsigned       pick;
        logic [MODE_W-1:0] mode;
        bit                calm;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            calm = ((n % 64) < 16) || (n >= RANDOM_ITEMS - CALM_TAIL);
            if (!calm && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 8));
            pick = $urandom_range(0, 99);
            if (pick < 72)
                mode = MODE_ADD;
            else if (pick < 92)
                mode = MODE_READ;
            else if (pick < 94)
                mode = MODE_CLEAR;
            else
                mode = MODE_UNUSED;
            issue(mode, random_rank(), random_component(), random_component(),
                  random_component());
        end
    endtask

    // reset, stimulus, drain, verdict
    initial begin
        scoreboard = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        start <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (scoreboard.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
